// ===== src/efpa_pkg.sv =====
// shared types and codes of the exact-fit page-run allocator
package efpa_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned COUNT_W = 11;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_NULL      = 2'd1;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;
  localparam logic [1:0] STATUS_RANGE     = 2'd3;

  typedef struct packed {
    logic               op;
    logic [COUNT_W-1:0] page_count;
    logic [ADDR_W-1:0]  address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  address_out;
    logic [1:0]         status;
    logic               from_free_list;
    logic [COUNT_W-1:0] free_runs;
  } out_item_t;

endpackage

// ===== src/exact_fit_page_run_allocator.sv =====
// top level of the exact-fit page-run allocator: sequencer, list registers and output stage
//
// channel  direction  handshake                   payload
// in       input      in_valid_i / in_stall_o     in_data_i  (op, page_count, address)
// out      output     out_valid_o / out_stall_i   out_data_o (address_out, status, ...)
// cfg      input      cfg_wr_en_i                 cfg_wr_data_i (heap_base)
//
// one transaction at a time; a valid free runs execute, second free and output states;
// an allocate runs execute, a walk of the free list if it is not empty, and output
// the list walk is set by the link memory: one read per cycle, next address from read data
// reset leaves the list empty and bump index at zero; the memories are not cleared
// a stalled result sits in the output register; the next transaction is taken but
// its result waits until the register frees
module exact_fit_page_run_allocator #(
  parameter int unsigned TABLE_PAGES = 1024,
  parameter int unsigned PAGE_BYTES  = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  efpa_pkg::in_item_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output efpa_pkg::out_item_t          out_data_o,
  input  logic                         cfg_wr_en_i,
  input  logic [efpa_pkg::ADDR_W-1:0]  cfg_wr_data_i
);
  import efpa_pkg::*;

  localparam int unsigned AW     = $clog2(TABLE_PAGES);
  localparam int unsigned IDX_W  = $clog2(TABLE_PAGES + 1);
  localparam int unsigned PB_SH  = $clog2(PAGE_BYTES);
  localparam int unsigned SUM_W  = ((IDX_W > COUNT_W) ? IDX_W : COUNT_W) + 1;
  localparam logic [IDX_W-1:0] LINK_NULL = IDX_W'(TABLE_PAGES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_FREE2 = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [IDX_W-1:0]   tail_q, tail_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0]   bump_q, bump_d;
  logic [ADDR_W-1:0]  heap_base_q;
  logic               out_valid_q, out_valid_d;

  in_item_t           item_q, item_d;
  logic [IDX_W-1:0]   cur_q, cur_d;
  logic [IDX_W-1:0]   prev_q, prev_d;
  logic [IDX_W-1:0]   steps_q, steps_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [ADDR_W-1:0]  res_addr_q, res_addr_d;
  logic [1:0]         res_status_q, res_status_d;
  logic               res_from_q, res_from_d;
  out_item_t          out_data_q, out_data_d;

  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               len_we;
  logic [AW-1:0]      len_waddr;
  logic               link_we;
  logic [AW-1:0]      link_waddr;
  logic [IDX_W-1:0]   link_wdata;
  logic [COUNT_W-1:0] len_rdata;
  logic [IDX_W-1:0]   link_rdata;

  logic               in_accept;
  logic               out_free;
  logic [SUM_W-1:0]   bump_sum;
  logic               bump_fits;
  logic [ADDR_W-1:0]  bump_addr;
  logic [ADDR_W-1:0]  cur_addr;
  logic [ADDR_W-1:0]  free_off;
  logic [ADDR_W-1:0]  free_idx;
  logic               free_oor;
  logic               list_linked;

  efpa_run_mem #(
    .DEPTH  (TABLE_PAGES),
    .AW     (AW),
    .LINK_W (IDX_W)
  ) u_run_mem (
    .clk_i        (clk_i),
    .rd_en_i      (rd_en),
    .rd_addr_i    (rd_addr),
    .len_we_i     (len_we),
    .len_waddr_i  (len_waddr),
    .len_wdata_i  (item_q.page_count),
    .link_we_i    (link_we),
    .link_waddr_i (link_waddr),
    .link_wdata_i (link_wdata),
    .len_rdata_o  (len_rdata),
    .link_rdata_o (link_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign bump_sum    = SUM_W'(bump_q) + SUM_W'(item_q.page_count);
  assign bump_fits   = (bump_sum <= SUM_W'(TABLE_PAGES));
  assign bump_addr   = heap_base_q + (ADDR_W'(bump_q) << PB_SH);
  assign cur_addr    = heap_base_q + (ADDR_W'(cur_q) << PB_SH);
  assign free_off    = item_q.address - heap_base_q;
  assign free_idx    = free_off >> PB_SH;
  assign free_oor    = ({1'b0, free_idx} + (ADDR_W + 1)'(item_q.page_count))
                       > (ADDR_W + 1)'(TABLE_PAGES);
  assign list_linked = (head_q < LINK_NULL) && (tail_q < LINK_NULL);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    bump_d       = bump_q;
    out_valid_d  = out_valid_q;
    item_d       = item_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    steps_d      = steps_q;
    idx_d        = idx_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    res_from_d   = res_from_q;
    out_data_d   = out_data_q;
    rd_en        = 1'b0;
    rd_addr      = cur_q[AW-1:0];
    len_we       = 1'b0;
    len_waddr    = idx_q[AW-1:0];
    link_we      = 1'b0;
    link_waddr   = idx_q[AW-1:0];
    link_wdata   = LINK_NULL;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          item_d  = in_data_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_addr_d   = '0;
        res_status_d = STATUS_DONE;
        res_from_d   = 1'b0;
        state_d      = S_OUT;
        if (item_q.op == OP_ALLOC) begin
          if (item_q.page_count == '0) begin
            res_status_d = STATUS_NULL;
          end else if (head_q < LINK_NULL) begin
            rd_en   = 1'b1;
            rd_addr = head_q[AW-1:0];
            cur_d   = head_q;
            prev_d  = LINK_NULL;
            steps_d = IDX_W'(1);
            state_d = S_WALK;
          end else if (!bump_fits) begin
            res_status_d = STATUS_EXHAUSTED;
          end else begin
            res_addr_d = bump_addr;
            bump_d     = IDX_W'(bump_sum);
          end
        end else begin
          if ((item_q.address == '0) || (item_q.page_count == '0)) begin
            res_status_d = STATUS_NULL;
          end else if (free_oor) begin
            res_status_d = STATUS_RANGE;
          end else begin
            idx_d      = free_idx[IDX_W-1:0];
            len_we     = 1'b1;
            len_waddr  = free_idx[AW-1:0];
            link_we    = list_linked;
            link_waddr = tail_q[AW-1:0];
            link_wdata = free_idx[IDX_W-1:0];
            state_d    = S_FREE2;
          end
        end
      end
      S_WALK: begin
        if (len_rdata == item_q.page_count) begin
          if (prev_q < LINK_NULL) begin
            link_we    = 1'b1;
            link_waddr = prev_q[AW-1:0];
            link_wdata = link_rdata;
          end else begin
            head_d = link_rdata;
          end
          if (tail_q == cur_q) begin
            tail_d = prev_q;
          end
          if (count_q != '0) begin
            count_d = count_q - COUNT_W'(1);
          end
          res_addr_d = cur_addr;
          res_from_d = 1'b1;
          state_d    = S_OUT;
        end else if ((link_rdata < LINK_NULL) && (steps_q < LINK_NULL)) begin
          rd_en   = 1'b1;
          rd_addr = link_rdata[AW-1:0];
          prev_d  = cur_q;
          cur_d   = link_rdata;
          steps_d = steps_q + IDX_W'(1);
        end else begin
          if (!bump_fits) begin
            res_status_d = STATUS_EXHAUSTED;
          end else begin
            res_addr_d = bump_addr;
            bump_d     = IDX_W'(bump_sum);
          end
          state_d = S_OUT;
        end
      end
      S_FREE2: begin
        link_we    = 1'b1;
        link_waddr = idx_q[AW-1:0];
        link_wdata = LINK_NULL;
        if (!list_linked) begin
          head_d = idx_q;
        end
        tail_d = idx_q;
        if (count_q != COUNT_MAX) begin
          count_d = count_q + COUNT_W'(1);
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d               = 1'b1;
          out_data_d.address_out    = res_addr_q;
          out_data_d.status         = res_status_q;
          out_data_d.from_free_list = res_from_q;
          out_data_d.free_runs      = count_q;
          state_d                   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= LINK_NULL;
      tail_q      <= LINK_NULL;
      count_q     <= '0;
      bump_q      <= '0;
      heap_base_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      bump_q      <= bump_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr_en_i) begin
        heap_base_q <= cfg_wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    steps_q      <= steps_d;
    idx_q        <= idx_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    res_from_q   <= res_from_d;
    out_data_q   <= out_data_d;
  end

  a_bump_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bump_q <= LINK_NULL)
    else $error("bump index beyond table");

  a_no_rd_wr_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && link_we))
    else $error("link memory read and write in one cycle");

  a_out_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside output state");

  a_list_hit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.from_free_list) |-> (out_data_q.status == STATUS_DONE))
    else $error("free list hit with failing status");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_EXEC))
    else $error("accepted transaction not executed");

endmodule

// ===== src/efpa_run_mem.sv =====
// run length and next link memories, one shared read port, one write port each
module efpa_run_mem #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned AW     = 10,
  parameter int unsigned LINK_W = 11
) (
  input  logic                        clk_i,
  input  logic                        rd_en_i,
  input  logic [AW-1:0]               rd_addr_i,
  input  logic                        len_we_i,
  input  logic [AW-1:0]               len_waddr_i,
  input  logic [efpa_pkg::COUNT_W-1:0] len_wdata_i,
  input  logic                        link_we_i,
  input  logic [AW-1:0]               link_waddr_i,
  input  logic [LINK_W-1:0]           link_wdata_i,
  output logic [efpa_pkg::COUNT_W-1:0] len_rdata_o,
  output logic [LINK_W-1:0]           link_rdata_o
);
  import efpa_pkg::*;

  logic [COUNT_W-1:0] len_mem  [DEPTH];
  logic [LINK_W-1:0]  link_mem [DEPTH];
  logic [COUNT_W-1:0] len_rdata_q;
  logic [LINK_W-1:0]  link_rdata_q;

  always_ff @(posedge clk_i) begin
    if (len_we_i) begin
      len_mem[len_waddr_i] <= len_wdata_i;
    end
    if (link_we_i) begin
      link_mem[link_waddr_i] <= link_wdata_i;
    end
    if (rd_en_i) begin
      len_rdata_q  <= len_mem[rd_addr_i];
      link_rdata_q <= link_mem[rd_addr_i];
    end
  end

  assign len_rdata_o  = len_rdata_q;
  assign link_rdata_o = link_rdata_q;

endmodule
